FILE: src/epcc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Ethernet protocol classifier and counter.
// No dependencies; the parser, counter unit, top and test files use it by scoped names.
package epcc_pkg;

	localparam int NUM_COUNTERS = 256;
	localparam int IDX_W        = 8;

	// Request kinds carried from the parser to the counter unit.
	localparam logic [1:0] OP_COUNT = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_TRUNC = 2'd2;

	// Result kinds.
	localparam logic KIND_VERDICT = 1'b0;
	localparam logic KIND_READ    = 1'b1;

	// Verdict codes.
	localparam logic [1:0] ACT_PASS = 2'd0;
	localparam logic [1:0] ACT_DROP = 2'd1;
	localparam logic [1:0] ACT_TX   = 2'd2;

	localparam logic [4:0]  ETH_HDR_LEN    = 5'd14;
	localparam logic [4:0]  TAG_LEN        = 5'd4;
	localparam logic [15:0] TYPE_TAG_Q     = 16'h8100;
	localparam logic [15:0] TYPE_TAG_AD    = 16'h88A8;
	localparam logic [15:0] TYPE_IPV4      = 16'h0800;
	localparam logic [15:0] TYPE_IPV6      = 16'h86DD;
	localparam logic [7:0]  IPV4_HDR_LEN   = 8'd20;
	localparam logic [7:0]  IPV6_HDR_LEN   = 8'd40;
	localparam logic [7:0]  IPV4_PROTO_OFS = 8'd9;
	localparam logic [7:0]  IPV6_NH_OFS    = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [6:0]  POS_MAX        = 7'd127;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] idx;
	} op_t;

endpackage

FILE: src/epcc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module epcc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/epcc_fifo.sv
`timescale 1ns / 1ps
// Small register-based queue with first-word fall-through output.
// No dependencies; depth must be a power of two.
module epcc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic                       full,
	output logic [$clog2(DEPTH):0]     count
);

	localparam int AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign count   = cnt_q;
	assign rdata   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/epcc_parser.sv
`timescale 1ns / 1ps
// Front end: walks the frame one byte per accepted cycle, skips VLAN tags, captures
// the IP protocol byte and emits one request per frame end or counter read. Uses epcc_pkg.
module epcc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                mode,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  logic [7:0]          counter_index,
	output logic                op_push,
	output epcc_pkg::op_t       op
);

	logic [6:0]  pos_q;
	logic [15:0] type_q;
	logic [1:0]  tags_q;
	logic [4:0]  hstart_q;
	logic [7:0]  proto_q;

	logic [15:0] type_n;
	logic [1:0]  tags_n;
	logic [4:0]  hs_n;
	logic [7:0]  proto_n;
	logic [7:0]  pos8;
	logic [7:0]  hs8;
	logic [7:0]  hsn8;
	logic [7:0]  len8;
	logic [7:0]  idx;

	always_comb begin
		pos8    = {1'b0, pos_q};
		hs8     = {3'b0, hstart_q};
		type_n  = type_q;
		tags_n  = tags_q;
		hs_n    = hstart_q;
		proto_n = proto_q;
		if (pos8 + 8'd2 == hs8 || pos8 + 8'd1 == hs8) begin
			type_n = {type_q[7:0], data_byte};
		end
		// A tag moves the network header four bytes further out.
		if (pos8 + 8'd1 == hs8 && tags_q < 2'd2 &&
		    (type_n == epcc_pkg::TYPE_TAG_Q || type_n == epcc_pkg::TYPE_TAG_AD)) begin
			hs_n   = hstart_q + epcc_pkg::TAG_LEN;
			tags_n = tags_q + 2'd1;
		end
		hsn8 = {3'b0, hs_n};
		if (pos8 >= hsn8) begin
			if (type_n == epcc_pkg::TYPE_IPV4 && pos8 == hsn8 + epcc_pkg::IPV4_PROTO_OFS) begin
				proto_n = data_byte;
			end
			if (type_n == epcc_pkg::TYPE_IPV6 && pos8 == hsn8 + epcc_pkg::IPV6_NH_OFS) begin
				proto_n = data_byte;
			end
		end
		len8 = pos8 + 8'd1;
		idx  = 8'd0;
		if (type_n == epcc_pkg::TYPE_IPV4 && len8 >= hsn8 + epcc_pkg::IPV4_HDR_LEN) begin
			idx = proto_n;
		end else if (type_n == epcc_pkg::TYPE_IPV6 &&
		             len8 >= hsn8 + epcc_pkg::IPV6_HDR_LEN) begin
			idx = proto_n;
		end

		op_push = accept && (mode || last_byte);
		if (mode) begin
			op.kind = epcc_pkg::OP_READ;
			op.idx  = counter_index;
		end else if (len8 < hsn8) begin
			op.kind = epcc_pkg::OP_TRUNC;
			op.idx  = 8'd0;
		end else begin
			op.kind = epcc_pkg::OP_COUNT;
			op.idx  = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			type_q   <= '0;
			tags_q   <= '0;
			hstart_q <= epcc_pkg::ETH_HDR_LEN;
			proto_q  <= '0;
		end else if (accept && !mode) begin
			if (last_byte) begin
				pos_q    <= '0;
				type_q   <= '0;
				tags_q   <= '0;
				hstart_q <= epcc_pkg::ETH_HDR_LEN;
				proto_q  <= '0;
			end else begin
				if (pos_q != epcc_pkg::POS_MAX) begin
					pos_q <= pos_q + 7'd1;
				end
				type_q   <= type_n;
				tags_q   <= tags_n;
				hstart_q <= hs_n;
				proto_q  <= proto_n;
			end
		end
	end

	// The header offset only ever takes the untagged, one-tag or two-tag value.
	a_hstart_legal: assert property (@(posedge clk) disable iff (!arst_n)
		hstart_q == 5'd14 || hstart_q == 5'd18 || hstart_q == 5'd22)
		else $error("header offset out of range");

	a_tags_match_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(tags_q == 2'd0) == (hstart_q == epcc_pkg::ETH_HDR_LEN))
		else $error("tag count and header offset disagree");

endmodule

FILE: src/epcc_counter_unit.sv
`timescale 1ns / 1ps
// Back end: takes requests from the queue, does the read-modify-write on the
// counter RAM and queues result items. Uses epcc_pkg, epcc_ram and epcc_fifo.
module epcc_counter_unit #(
	parameter int COUNT_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   default_action,
	input  logic                   op_empty,
	input  epcc_pkg::op_t          op,
	output logic                   op_pop,
	input  logic                   pop,
	output logic                   empty,
	output logic                   result_kind,
	output logic [1:0]             action,
	output logic                   was_counted,
	output logic [7:0]             protocol,
	output logic [COUNT_WIDTH-1:0] count_value
);

	localparam int OUT_DEPTH = 4;
	localparam int RES_W     = 1 + 2 + 1 + 8 + COUNT_WIDTH;
	localparam int AW        = $clog2(epcc_pkg::NUM_COUNTERS);

	logic [epcc_pkg::NUM_COUNTERS-1:0] vld_q;
	logic                   vld_s1;
	logic [1:0]             kind_s1;
	logic [AW-1:0]          idx_s1;
	logic                   entry_ok_s1;
	logic                   wr_en_q;
	logic [AW-1:0]          wr_addr_q;
	logic [COUNT_WIDTH-1:0] wr_data_q;

	logic [COUNT_WIDTH-1:0] rdata;
	logic [COUNT_WIDTH-1:0] base;
	logic [COUNT_WIDTH-1:0] incr;
	logic                   we;
	logic [RES_W-1:0]       res;
	logic [RES_W-1:0]       res_head;
	logic [$clog2(OUT_DEPTH):0] out_cnt;
	logic                   out_full;
	logic                   out_push;

	// Only issue when the result queue has room for everything in flight.
	assign op_pop   = !op_empty &&
	                  (4'(out_cnt) + 4'(vld_s1) < 4'(OUT_DEPTH));
	assign out_push = vld_s1;

	always_comb begin
		// The entry written on the previous edge is not yet in the read data.
		if (wr_en_q && wr_addr_q == idx_s1) begin
			base = wr_data_q;
		end else if (entry_ok_s1) begin
			base = rdata;
		end else begin
			base = '0;
		end
		incr = base + 1'b1;
		we   = vld_s1 && (kind_s1 == epcc_pkg::OP_COUNT);
		case (kind_s1)
			epcc_pkg::OP_COUNT: begin
				res = {epcc_pkg::KIND_VERDICT,
				       (idx_s1 == epcc_pkg::PROTO_UDP) ? epcc_pkg::ACT_TX
				                                       : {1'b0, default_action},
				       1'b1, idx_s1, incr};
			end
			epcc_pkg::OP_READ: begin
				res = {epcc_pkg::KIND_READ, epcc_pkg::ACT_PASS, 1'b0, idx_s1, base};
			end
			default: begin
				res = {epcc_pkg::KIND_VERDICT, {1'b0, default_action}, 1'b0, 8'd0,
				       {COUNT_WIDTH{1'b0}}};
			end
		endcase
	end

	epcc_ram #(
		.WIDTH (COUNT_WIDTH),
		.DEPTH (epcc_pkg::NUM_COUNTERS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (idx_s1),
		.wdata (incr),
		.raddr (op.idx),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		kind_s1     <= op.kind;
		idx_s1      <= op.idx;
		entry_ok_s1 <= vld_q[op.idx];
		wr_addr_q   <= idx_s1;
		wr_data_q   <= incr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			wr_en_q <= 1'b0;
			vld_q   <= '0;
		end else begin
			vld_s1  <= op_pop;
			wr_en_q <= we;
			if (we) begin
				vld_q[idx_s1] <= 1'b1;
			end
		end
	end

	epcc_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (res),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty),
		.full   (out_full),
		.count  (out_cnt)
	);

	assign {result_kind, action, was_counted, protocol, count_value} = res_head;

	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full || pop)
		else $error("result queue overflow");

	a_write_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en_q |-> vld_q[wr_addr_q])
		else $error("written counter not marked valid");

endmodule

FILE: src/ethernet_protocol_classifier_counter.sv
`timescale 1ns / 1ps
// Ethernet protocol classifier with 256 per-protocol frame counters.
// Throughput: one frame byte or counter read per cycle while full is low.
// A verdict or read reply passes the request queue, then the RAM read and
// update stage, before it reaches the head of the result queue.
// Reset clears all counters at once through per-entry valid bits; no sweep.
// Depends on epcc_pkg, epcc_fifo, epcc_parser and epcc_counter_unit.
module ethernet_protocol_classifier_counter #(
	parameter int COUNT_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   mode,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	input  logic [7:0]             counter_index,
	output logic                   empty,
	input  logic                   pop,
	output logic                   result_kind,
	output logic [1:0]             action,
	output logic                   was_counted,
	output logic [7:0]             protocol,
	output logic [COUNT_WIDTH-1:0] count_value,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	localparam int OP_DEPTH = 4;

	logic          default_action_q;
	logic          accept;
	logic          op_push;
	epcc_pkg::op_t op_in;
	epcc_pkg::op_t op_out;
	logic          op_pop;
	logic          op_empty;
	logic          op_full;
	logic [$clog2(OP_DEPTH):0] op_cnt;

	assign cfg_ready = 1'b1;
	assign full      = op_full;
	assign accept    = push && !op_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_action_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			default_action_q <= cfg_data;
		end
	end

	epcc_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.mode          (mode),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.counter_index (counter_index),
		.op_push       (op_push),
		.op            (op_in)
	);

	epcc_fifo #(
		.WIDTH ($bits(epcc_pkg::op_t)),
		.DEPTH (OP_DEPTH)
	) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_in),
		.pop    (op_pop),
		.rdata  (op_out),
		.empty  (op_empty),
		.full   (op_full),
		.count  (op_cnt)
	);

	epcc_counter_unit #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_counter_unit (
		.clk            (clk),
		.arst_n         (arst_n),
		.default_action (default_action_q),
		.op_empty       (op_empty),
		.op             (op_out),
		.op_pop         (op_pop),
		.pop            (pop),
		.empty          (empty),
		.result_kind    (result_kind),
		.action         (action),
		.was_counted    (was_counted),
		.protocol       (protocol),
		.count_value    (count_value)
	);

	a_op_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		op_cnt <= ($clog2(OP_DEPTH)+1)'(OP_DEPTH))
		else $error("request queue count out of range");

endmodule

FILE: test/epcc_classifier_check.sv
`timescale 1ns / 1ps
// Checker for the Ethernet protocol classifier: watches the request, result and
// register channels, predicts each reply and compares it. Depends on epcc_pkg.
module epcc_classifier_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic        mode,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [7:0]  counter_index,
	input  logic        empty,
	input  logic        pop,
	input  logic        result_kind,
	input  logic [1:0]  action,
	input  logic        was_counted,
	input  logic [7:0]  protocol,
	input  logic [63:0] count_value,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          mismatches,
	output int          outstanding
);

	typedef struct packed {
		logic        kind;
		logic [1:0]  act;
		logic        counted;
		logic [7:0]  proto;
		logic [63:0] count;
	} reply_t;

	reply_t      awaited_replies[$];
	logic        drop_default;
	logic [6:0]  frame_pos;
	logic [15:0] ether_type;
	logic [1:0]  tags_skipped;
	logic [4:0]  l3_start;
	logic [7:0]  proto_seen;
	logic [63:0] proto_frames [epcc_pkg::NUM_COUNTERS];

	task automatic note_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	task automatic clear_frame();
		frame_pos    = '0;
		ether_type   = '0;
		tags_skipped = '0;
		l3_start     = epcc_pkg::ETH_HDR_LEN;
		proto_seen   = '0;
	endtask

	// Advances the frame state by one request and tells whether it yields a reply.
	task automatic classify(input logic m, input logic [7:0] b, input logic lst,
			input logic [7:0] sel, output bit has_reply, output reply_t r);
		int   pos;
		int   start;
		int   len;
		logic [7:0] idx;
		has_reply = 1'b0;
		r = '0;
		if (m) begin
			has_reply = 1'b1;
			r.kind    = epcc_pkg::KIND_READ;
			r.act     = epcc_pkg::ACT_PASS;
			r.proto   = sel;
			r.count   = proto_frames[sel];
			return;
		end
		pos   = int'(frame_pos);
		start = int'(l3_start);
		if (pos + 2 == start || pos + 1 == start)
			ether_type = {ether_type[7:0], b};
		if (pos + 1 == start && tags_skipped < 2 &&
				(ether_type == epcc_pkg::TYPE_TAG_Q ||
				 ether_type == epcc_pkg::TYPE_TAG_AD)) begin
			l3_start     = l3_start + epcc_pkg::TAG_LEN;
			tags_skipped = tags_skipped + 1'b1;
		end
		start = int'(l3_start);
		if (pos >= start) begin
			if (ether_type == epcc_pkg::TYPE_IPV4 &&
					pos == start + int'(epcc_pkg::IPV4_PROTO_OFS))
				proto_seen = b;
			if (ether_type == epcc_pkg::TYPE_IPV6 &&
					pos == start + int'(epcc_pkg::IPV6_NH_OFS))
				proto_seen = b;
		end
		if (frame_pos < epcc_pkg::POS_MAX)
			frame_pos = frame_pos + 1'b1;
		if (!lst)
			return;
		has_reply = 1'b1;
		r.kind    = epcc_pkg::KIND_VERDICT;
		len       = pos + 1;
		// A frame cut short inside the MAC or tag headers is not counted.
		if (len < start) begin
			r.act = drop_default ? epcc_pkg::ACT_DROP : epcc_pkg::ACT_PASS;
			clear_frame();
			return;
		end
		idx = '0;
		if (ether_type == epcc_pkg::TYPE_IPV4 &&
				len >= start + int'(epcc_pkg::IPV4_HDR_LEN))
			idx = proto_seen;
		else if (ether_type == epcc_pkg::TYPE_IPV6 &&
				len >= start + int'(epcc_pkg::IPV6_HDR_LEN))
			idx = proto_seen;
		proto_frames[idx] = proto_frames[idx] + 64'd1;
		r.act     = (idx == epcc_pkg::PROTO_UDP) ? epcc_pkg::ACT_TX :
		            (drop_default ? epcc_pkg::ACT_DROP : epcc_pkg::ACT_PASS);
		r.counted = 1'b1;
		r.proto   = idx;
		r.count   = proto_frames[idx];
		clear_frame();
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t next_reply;
		bit     has_reply;
		if (!arst_n) begin
			awaited_replies.delete();
			drop_default = 1'b0;
			clear_frame();
			for (int i = 0; i < epcc_pkg::NUM_COUNTERS; i++)
				proto_frames[i] = '0;
			mismatches  = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				drop_default = cfg_data;
			if (pop && !empty) begin
				if (awaited_replies.size() == 0) begin
					note_mismatch("result with none expected, protocol", 64'(protocol),
						'0);
				end else begin
					want = awaited_replies.pop_front();
					if (result_kind !== want.kind)
						note_mismatch("result_kind", 64'(result_kind), 64'(want.kind));
					if (action !== want.act)
						note_mismatch("action", 64'(action), 64'(want.act));
					if (was_counted !== want.counted)
						note_mismatch("was_counted", 64'(was_counted), 64'(want.counted));
					if (protocol !== want.proto)
						note_mismatch("protocol", 64'(protocol), 64'(want.proto));
					if (count_value !== want.count)
						note_mismatch("count_value", count_value, want.count);
				end
			end
			if (push && !full) begin
				classify(mode, data_byte, last_byte, counter_index, has_reply, next_reply);
				if (has_reply)
					awaited_replies.push_back(next_reply);
			end
			outstanding <= awaited_replies.size();
		end
	end

endmodule

FILE: test/tb_ethernet_protocol_classifier_counter.sv
`timescale 1ns / 1ps
// Testbench top for the Ethernet protocol classifier: drives frames, counter reads
// and the default-verdict register. Depends on epcc_pkg and epcc_classifier_check.
module tb_ethernet_protocol_classifier_counter;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int TAIL_CYCLES    = 20;

	typedef logic [7:0] frame_t [$];

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        mode;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic [7:0]  counter_index;
	logic        empty;
	logic        pop;
	logic        result_kind;
	logic [1:0]  action;
	logic        was_counted;
	logic [7:0]  protocol;
	logic [63:0] count_value;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_data;

	int mismatches;
	int outstanding;
	int items_sent;
	int replies_caused;
	int idle_cycles;
	int pop_hold;
	bit calm;

	ethernet_protocol_classifier_counter dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.mode(mode), .data_byte(data_byte), .last_byte(last_byte),
		.counter_index(counter_index),
		.empty(empty), .pop(pop),
		.result_kind(result_kind), .action(action), .was_counted(was_counted),
		.protocol(protocol), .count_value(count_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	epcc_classifier_check chk (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.mode(mode), .data_byte(data_byte), .last_byte(last_byte),
		.counter_index(counter_index),
		.empty(empty), .pop(pop),
		.result_kind(result_kind), .action(action), .was_counted(was_counted),
		.protocol(protocol), .count_value(count_value),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Result side: random stall bursts, none once the run turns calm.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (calm) begin
			pop <= 1'b1;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold--;
		end else if ($urandom_range(0, 9) == 0) begin
			pop <= 1'b0;
			pop_hold = $urandom_range(0, 10);
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_item(input logic m, input logic [7:0] b, input logic lst,
			input logic [7:0] sel);
		if (!calm && $urandom_range(0, 7) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		push          <= 1'b1;
		mode          <= m;
		data_byte     <= b;
		last_byte     <= lst;
		counter_index <= sel;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	task automatic read_counter(input logic [7:0] sel);
		// Frame fields are ignored on a read, so they carry random values.
		send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sel);
		replies_caused++;
	endtask

	task automatic send_frame(input frame_t f, input int read_pct);
		for (int i = 0; i < f.size(); i++) begin
			if ($urandom_range(0, 99) < read_pct)
				read_counter(8'($urandom_range(0, 255)));
			send_item(1'b0, f[i], i == f.size() - 1, 8'($urandom_range(0, 255)));
		end
		replies_caused++;
	endtask

	function automatic frame_t build_frame(input int ntags, input logic [2:0] ad_mask,
			input logic [15:0] etype, input int l3_len, input logic [7:0] proto_val);
		frame_t      f;
		logic [15:0] tag;
		repeat (12) f.push_back(8'($urandom_range(0, 255)));
		for (int i = 0; i < ntags; i++) begin
			tag = ad_mask[i] ? epcc_pkg::TYPE_TAG_AD : epcc_pkg::TYPE_TAG_Q;
			f.push_back(tag[15:8]);
			f.push_back(tag[7:0]);
			f.push_back(8'($urandom_range(0, 255)));
			f.push_back(8'($urandom_range(0, 255)));
		end
		f.push_back(etype[15:8]);
		f.push_back(etype[7:0]);
		for (int i = 0; i < l3_len; i++) begin
			if ((etype == epcc_pkg::TYPE_IPV4 && i == int'(epcc_pkg::IPV4_PROTO_OFS)) ||
					(etype == epcc_pkg::TYPE_IPV6 && i == int'(epcc_pkg::IPV6_NH_OFS)))
				f.push_back(proto_val);
			else
				f.push_back(8'($urandom_range(0, 255)));
		end
		return f;
	endfunction

	task automatic random_frame(output frame_t f);
		int          ntags;
		int          pick;
		int          l3_len;
		int          keep;
		logic [15:0] etype;
		logic [7:0]  proto_val;
		if ($urandom_range(0, 99) < 12) begin
			f.delete();
			repeat ($urandom_range(1, 40)) f.push_back(8'($urandom_range(0, 255)));
			return;
		end
		pick  = $urandom_range(0, 9);
		ntags = (pick < 5) ? 0 : (pick < 8) ? 1 : (pick == 8) ? 2 : 3;
		pick  = $urandom_range(0, 9);
		if (pick < 5)
			etype = epcc_pkg::TYPE_IPV4;
		else if (pick < 8)
			etype = epcc_pkg::TYPE_IPV6;
		else if (pick == 8)
			etype = 16'($urandom_range(0, 65535));
		else
			etype = epcc_pkg::TYPE_TAG_Q;
		proto_val = ($urandom_range(0, 9) < 3) ? epcc_pkg::PROTO_UDP
		                                       : 8'($urandom_range(0, 255));
		if (etype == epcc_pkg::TYPE_IPV4)
			l3_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 25) : $urandom_range(20, 28);
		else if (etype == epcc_pkg::TYPE_IPV6)
			l3_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 45) : $urandom_range(40, 48);
		else
			l3_len = $urandom_range(0, 10);
		// Now and then a long frame, which may saturate the byte position.
		if ($urandom_range(0, 49) == 0)
			l3_len = $urandom_range(100, 120);
		f = build_frame(ntags, 3'($urandom_range(0, 7)), etype, l3_len, proto_val);
		if ($urandom_range(0, 9) == 0) begin
			keep = $urandom_range(1, 14 + 4 * ntags);
			while (f.size() > keep) void'(f.pop_back());
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_default(input logic drop);
		cfg_valid <= 1'b1;
		cfg_data  <= drop;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int item_goal, input int reply_goal);
		int     items_start;
		int     replies_start;
		frame_t f;
		items_start   = items_sent;
		replies_start = replies_caused;
		while (items_sent - items_start < item_goal ||
				replies_caused - replies_start < reply_goal) begin
			random_frame(f);
			send_frame(f, 8);
			if ($urandom_range(0, 3) == 0)
				read_counter(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		frame_t f;
		arst_n        = 1'b0;
		push          = 1'b0;
		mode          = 1'b0;
		data_byte     = '0;
		last_byte     = 1'b0;
		counter_index = '0;
		cfg_valid     = 1'b0;
		cfg_data      = 1'b0;
		pop_hold      = 0;
		calm          = 1'b0;
		items_sent    = 0;
		replies_caused = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_default(1'b0);
		read_counter(8'd0);
		read_counter(8'd255);
		// A one-byte frame and one that ends inside the EtherType.
		f = build_frame(0, 3'b000, epcc_pkg::TYPE_IPV4, 0, 8'd0);
		while (f.size() > 1) void'(f.pop_back());
		send_frame(f, 0);
		f = build_frame(0, 3'b000, epcc_pkg::TYPE_IPV4, 0, 8'd0);
		while (f.size() > 13) void'(f.pop_back());
		send_frame(f, 0);
		send_frame(build_frame(0, 3'b000, epcc_pkg::TYPE_IPV4, 20, epcc_pkg::PROTO_UDP), 0);
		send_frame(build_frame(0, 3'b000, epcc_pkg::TYPE_IPV4, 19, 8'd6), 0);
		send_frame(build_frame(0, 3'b000, epcc_pkg::TYPE_IPV6, 40, 8'hFF), 0);
		send_frame(build_frame(0, 3'b000, epcc_pkg::TYPE_IPV6, 39, 8'd58), 0);
		// Reads interleaved with a tagged frame must not disturb its parsing.
		send_frame(build_frame(1, 3'b000, epcc_pkg::TYPE_IPV4, 20, 8'd6), 25);
		send_frame(build_frame(2, 3'b001, epcc_pkg::TYPE_IPV6, 40, epcc_pkg::PROTO_UDP), 0);
		// The third tag is not skipped, so the frame is not seen as IP.
		send_frame(build_frame(3, 3'b010, epcc_pkg::TYPE_IPV4, 20, 8'd6), 0);
		f = build_frame(1, 3'b001, epcc_pkg::TYPE_IPV4, 20, 8'd6);
		while (f.size() > 16) void'(f.pop_back());
		send_frame(f, 0);
		send_frame(build_frame(0, 3'b000, 16'h0806, 5, 8'd0), 0);
		send_frame(build_frame(0, 3'b000, epcc_pkg::TYPE_IPV4, 120, 8'h80), 0);
		read_counter(epcc_pkg::PROTO_UDP);
		read_counter(8'd0);
		read_counter(8'd6);
		read_counter(8'd255);
		read_counter(8'd128);
		wait_drained();

		write_default(1'b1);
		run_phase(30, 3);
		wait_drained();
		write_default(1'b0);
		run_phase(15, 2);
		wait_drained();
		write_default(1'b1);
		calm = 1'b1;
		run_phase(15, 2);

		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
